FILE: hw/rtl/three_floor_elevator_controller_assert.svh
// ============================================================================
// Assertion macros for the three-floor elevator controller
// Concurrent checks clocked on aclk and masked while aresetn is low; they
// compile to nothing in synthesis.
// ============================================================================
`ifndef THREE_FLOOR_ELEVATOR_CONTROLLER_ASSERT_SVH
`define THREE_FLOOR_ELEVATOR_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define TFEC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);
// condition must never be seen at a clock edge out of reset
`define TFEC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);
`else
`define TFEC_ASSERT(label, prop, msg)
`define TFEC_ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: hw/rtl/tfec_pkg.sv
// ============================================================================
// tfec_pkg
// Shared types, button and display codes and small helper functions of the
// three-floor elevator controller.
// ============================================================================
package tfec_pkg;

    // active-low button patterns
    localparam logic [3:0] BTN_FLOOR0 = 4'hE;
    localparam logic [3:0] BTN_FLOOR1 = 4'hD;
    localparam logic [3:0] BTN_FLOOR2 = 4'hB;
    localparam logic [3:0] BTN_HOLD   = 4'h7;

    // seven-segment codes
    localparam logic [6:0] SEG_FLOOR0 = 7'h3f;
    localparam logic [6:0] SEG_FLOOR1 = 7'h06;
    localparam logic [6:0] SEG_FLOOR2 = 7'h5b;

    // register reset values
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd150;
    localparam logic [11:0] STEP_GROUPS_RESET = 12'd230;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_PHASE_TICKS = 1'b0,
        REG_STEP_GROUPS = 1'b1
    } cfg_index_t;

    // one input word: bits [3:0] buttons, bit [4] tick
    typedef struct packed {
        logic       tick;
        logic [3:0] buttons;
    } item_t;

    // one result word, lowest bits first: coils, segments, floor, moving, held
    typedef struct packed {
        logic       held;
        logic       moving;
        logic [1:0] current_floor;
        logic [6:0] segments;
        logic [3:0] coils;
    } result_t;

    // configuration as seen by the controller
    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [11:0] step_groups;
    } cfg_t;

    // decoded floor call
    typedef struct packed {
        logic       valid;
        logic [1:0] floor;
    } call_t;

    function automatic logic [6:0] seg_of(input logic [1:0] floor);
        logic [6:0] code;
        case (floor)
            2'd1:    code = SEG_FLOOR1;
            2'd2:    code = SEG_FLOOR2;
            default: code = SEG_FLOOR0;
        endcase
        return code;
    endfunction

    function automatic call_t call_decode(input logic [3:0] buttons);
        call_t c;
        c.valid = 1'b1;
        c.floor = 2'd0;
        case (buttons)
            BTN_FLOOR0: c.floor = 2'd0;
            BTN_FLOOR1: c.floor = 2'd1;
            BTN_FLOOR2: c.floor = 2'd2;
            default:    c.valid = 1'b0;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/tfec_in_reg.sv
// ============================================================================
// tfec_in_reg
// Input register: captures one button/tick word and holds it until the
// controller takes it.
// ============================================================================
module tfec_in_reg
    import tfec_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // free when empty or when the held word leaves this cycle
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: hw/rtl/tfec_ctrl.sv
// ============================================================================
// tfec_ctrl
// Elevator state, next-state logic for one word, and the result register.
// ============================================================================
`include "three_floor_elevator_controller_assert.svh"

module tfec_ctrl
    import tfec_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    typedef struct packed {
        logic [1:0]  floor_now;
        logic [1:0]  floor_target;
        logic [2:0]  pending;
        logic        serving;
        logic        moving;
        logic        going_up;
        logic [1:0]  phase;
        logic [15:0] tick_cnt;
        logic [12:0] group_cnt;
        logic [3:0]  coil;
        logic [6:0]  seg;
    } st_t;

    typedef struct packed {
        logic       found;
        logic [1:0] floor;
    } pick_t;

    st_t     state_reg;
    st_t     state_next;
    logic    hold_reg;
    logic    hold_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;
    result_t result_next;
    logic    advance;
    call_t   call;

    // ---- helpers ----------------------------------------------------------

    function automatic logic [3:0] phase_coil(input logic [1:0] k, input logic up);
        return up ? (4'b0001 << k) : (4'b1000 >> k);
    endfunction

    // four-phase groups for a move between two floors
    function automatic logic [12:0] move_groups(input logic [1:0] a, input logic [1:0] b,
                                               input logic [11:0] sg);
        logic [1:0] span;
        span = (a > b) ? (a - b) : (b - a);
        return (span == 2'd2) ? {sg, 1'b0} : {1'b0, sg};
    endfunction

    function automatic pick_t lowest(input logic [2:0] p);
        pick_t r;
        r.found = |p;
        r.floor = p[0] ? 2'd0 : (p[1] ? 2'd1 : 2'd2);
        return r;
    endfunction

    // arrival at floor_target, then start on the lowest latched floor
    function automatic st_t do_arrive(input st_t s, input logic [11:0] sg);
        st_t        r;
        logic [2:0] p;
        pick_t      pk;
        logic [1:0] hi;
        r           = s;
        r.moving    = 1'b0;
        r.serving   = 1'b0;
        r.floor_now = s.floor_target;
        r.seg       = seg_of(s.floor_target);
        p           = s.pending;
        pk          = lowest(p);
        // a latched call for the floor just reached is dropped
        if (pk.found && pk.floor == s.floor_target) begin
            p  = p & ~(3'b001 << pk.floor);
            pk = lowest(p);
        end
        hi = s.pending[2] ? 2'd2 : (s.pending[1] ? 2'd1 : 2'd0);
        if (!pk.found) begin
            r.pending = p;
        end else if (sg == '0) begin
            // zero-length moves chain through every latched floor at once
            r.pending      = 3'b000;
            r.floor_now    = hi;
            r.floor_target = hi;
            r.seg          = seg_of(hi);
            r.phase        = 2'd0;
            r.tick_cnt     = '0;
            r.group_cnt    = '0;
        end else begin
            r.pending      = p & ~(3'b001 << pk.floor);
            r.floor_target = pk.floor;
            r.going_up     = pk.floor > s.floor_target;
            r.serving      = 1'b1;
            r.moving       = 1'b1;
            r.group_cnt    = move_groups(pk.floor, s.floor_target, sg);
            r.phase        = 2'd0;
            r.tick_cnt     = '0;
            r.seg          = seg_of(pk.floor);
            r.coil         = phase_coil(2'd0, pk.floor > s.floor_target);
        end
        return r;
    endfunction

    // ---- handshake --------------------------------------------------------

    assign in_ready = !out_valid_reg || out_ready;
    assign advance  = in_valid && in_ready;
    assign call     = call_decode(in_item.buttons);

    // ---- next state for one word -----------------------------------------

    always_comb begin
        logic [15:0] limit;
        logic [15:0] t1;
        logic [1:0]  ph;
        logic [12:0] g;
        state_next = state_reg;
        hold_next  = hold_reg;
        limit      = (cfg.phase_ticks == '0) ? 16'd1 : cfg.phase_ticks;
        t1         = state_reg.tick_cnt + 16'd1;
        ph         = state_reg.phase + 2'd1;
        g          = (state_reg.group_cnt == '0) ? '0 : state_reg.group_cnt - 13'd1;
        if (!state_reg.moving) begin
            // idle: a call to another floor starts an ordinary move
            if (!hold_reg && call.valid && call.floor != state_reg.floor_now) begin
                state_next.floor_target = call.floor;
                state_next.going_up     = call.floor > state_reg.floor_now;
                state_next.serving      = 1'b0;
                state_next.group_cnt    = move_groups(call.floor, state_reg.floor_now,
                                                      cfg.step_groups);
                state_next.phase        = 2'd0;
                state_next.tick_cnt     = '0;
                if (cfg.step_groups == '0) begin
                    state_next = do_arrive(state_next, cfg.step_groups);
                end else begin
                    state_next.moving = 1'b1;
                    state_next.coil   = phase_coil(2'd0, call.floor > state_reg.floor_now);
                end
            end
            hold_next = (in_item.buttons == BTN_HOLD);
        end else begin
            // latch calls during an ordinary move
            if (!state_reg.serving && call.valid && call.floor != state_reg.floor_target) begin
                state_next.pending = state_reg.pending | (3'b001 << call.floor);
            end
            // step timing
            if (in_item.tick) begin
                if (t1 >= limit) begin
                    state_next.tick_cnt = '0;
                    state_next.phase    = ph;
                    if (ph == 2'd0) begin
                        state_next.group_cnt = g;
                        if (g == '0) begin
                            state_next = do_arrive(state_next, cfg.step_groups);
                        end else begin
                            state_next.coil = phase_coil(ph, state_reg.going_up);
                        end
                    end else begin
                        state_next.coil = phase_coil(ph, state_reg.going_up);
                    end
                end else begin
                    state_next.tick_cnt = t1;
                end
            end
        end
    end

    // ---- result word ------------------------------------------------------

    always_comb begin
        result_next.coils         = state_next.coil;
        result_next.segments      = state_next.seg;
        result_next.current_floor = state_next.floor_now;
        result_next.moving        = state_next.moving;
        result_next.held          = hold_next;
        out_valid_next            = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '{floor_now: 2'd0, floor_target: 2'd0, pending: 3'b000,
                               serving: 1'b0, moving: 1'b0, going_up: 1'b0,
                               phase: 2'd0, tick_cnt: 16'd0, group_cnt: 13'd0,
                               coil: 4'b0000, seg: SEG_FLOOR0};
            hold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
                hold_reg  <= hold_next;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    // ---- checks -----------------------------------------------------------

    `TFEC_ASSERT(a_serving_moving, state_reg.serving |-> state_reg.moving,
        "serving while stopped")
    `TFEC_ASSERT_NEVER(a_idle_pending, !state_reg.moving && state_reg.pending != 3'b000,
        "calls left latched at rest")
    `TFEC_ASSERT(a_coil_onehot, state_reg.moving |-> $onehot(state_reg.coil),
        "coil drive not one-hot while stepping")
    `TFEC_ASSERT(a_display_floor,
        (state_reg.moving && !state_reg.serving) |-> state_reg.seg == seg_of(state_reg.floor_now),
        "display off the floor left")
    `TFEC_ASSERT(a_result_floor, advance |=> out_result.current_floor == state_reg.floor_now,
        "result floor differs from state")

endmodule

FILE: hw/rtl/three_floor_elevator_controller.sv
// ============================================================================
// three_floor_elevator_controller
// Three-floor elevator control with four-coil stepper drive.
// ============================================================================
// Takes one word per clock when the output side is ready: a sample of the
// active-low call buttons and a 50 us tick flag, and returns one word per
// input word with the coil drive, the seven-segment code, the current floor
// and the moving and hold flags as they stand after that sample. A word
// passes an input register and then the result register before its result
// is presented; both stages advance every cycle when the output side is ready.
// Car travel time is counted in tick flags: step_groups four-phase groups per
// floor, each phase held phase_ticks ticks. Write the registers only with no
// word in flight.
module three_floor_elevator_controller
    import tfec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [3:0] buttons, [4] tick, [7:5] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // [3:0] coils, [10:4] segments,
                                      // [12:11] current_floor, [13] moving,
                                      // [14] held, [15] zero
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_wr_index,
    input  logic [15:0] cfg_wr_data
);

    logic [15:0] phase_ticks_reg;
    logic [11:0] step_groups_reg;
    cfg_t        cfg;
    item_t       s_item;
    logic        ctrl_valid;
    logic        ctrl_ready;
    item_t       ctrl_item;
    result_t     m_result;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
            step_groups_reg <= STEP_GROUPS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                REG_PHASE_TICKS: phase_ticks_reg <= cfg_wr_data;
                REG_STEP_GROUPS: step_groups_reg <= cfg_wr_data[11:0];
                default: ;
            endcase
        end
    end

    assign cfg.phase_ticks = phase_ticks_reg;
    assign cfg.step_groups = step_groups_reg;

    assign s_item.buttons = s_tdata[3:0];
    assign s_item.tick    = s_tdata[4];

    tfec_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (ctrl_valid),
        .out_ready (ctrl_ready),
        .out_item  (ctrl_item)
    );

    tfec_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (ctrl_valid),
        .in_ready   (ctrl_ready),
        .in_item    (ctrl_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (m_result)
    );

    assign m_tdata = {1'b0, m_result};

endmodule

FILE: tb/tb_three_floor_elevator_controller.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_three_floor_elevator_controller
// Self-checking testbench for the three-floor elevator controller.
// Button and tick words go in on the input stream. A cycle-free model of the
// car (floor, target, latched calls, coil phase, tick and group counters)
// predicts the status word that each one produces. Every status word on the
// result stream is compared field by field against the oldest prediction.
// Directed tests cover hold, calls to the current floor, latched calls and
// their ascending service, zero register settings and the largest phase
// hold. Random traffic then runs under several register settings. Both
// stream sides idle at random except where a test switches idling off.
// ============================================================================
module tb_three_floor_elevator_controller;
    import tfec_pkg::*;

    // button patterns the package does not name
    localparam logic [3:0] BTN_NONE = 4'hF;
    localparam logic [3:0] BTN_ALL  = 4'h0;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_wr_en;
    logic [0:0]  cfg_wr_index;
    logic [15:0] cfg_wr_data;

    three_floor_elevator_controller uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // car model state, reset values
    logic [15:0] cfg_phase_ticks = PHASE_TICKS_RESET;
    logic [11:0] cfg_step_groups = STEP_GROUPS_RESET;
    logic [1:0]  car_floor       = 2'd0;
    logic [1:0]  car_dest        = 2'd0;
    logic [2:0]  calls_latched   = 3'd0;
    logic        on_latched_run  = 1'b0;
    logic        car_moving      = 1'b0;
    logic        car_up          = 1'b0;
    logic        hold_on         = 1'b0;
    logic [1:0]  coil_phase      = 2'd0;
    logic [15:0] tick_cnt        = 16'd0;
    logic [12:0] groups_left     = 13'd0;
    logic [3:0]  coil_out        = 4'd0;
    logic [6:0]  seg_out         = SEG_FLOOR0;

    // predicted status words, oldest first
    result_t     car_status_q[$];
    int unsigned mismatches    = 0;
    int unsigned words_checked = 0;
    bit          tx_gaps_on    = 1'b1;
    bit          rx_stalls_on  = 1'b1;

    // 50 MHz clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // hard stop
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // car model
    // ------------------------------------------------------------------
    function automatic int called_floor(input logic [3:0] btn);
        case (btn)
            BTN_FLOOR0: return 0;
            BTN_FLOOR1: return 1;
            BTN_FLOOR2: return 2;
            default:    return -1;
        endcase
    endfunction

    function automatic logic [6:0] floor_segments(input logic [1:0] f);
        case (f)
            2'd1:    return SEG_FLOOR1;
            2'd2:    return SEG_FLOOR2;
            default: return SEG_FLOOR0;
        endcase
    endfunction

    function automatic logic [3:0] coil_for_phase();
        return car_up ? (4'b0001 << coil_phase) : (4'b1000 >> coil_phase);
    endfunction

    // set up a trip; the caller decides between arrival and stepping
    function automatic void begin_trip(input logic [1:0] dest, input logic from_latch);
        logic [1:0] span;
        span = (dest > car_floor) ? dest - car_floor : car_floor - dest;
        car_dest       = dest;
        car_up         = dest > car_floor;
        on_latched_run = from_latch;
        groups_left    = 13'(span) * 13'(cfg_step_groups);
        coil_phase     = 2'd0;
        tick_cnt       = 16'd0;
        if (from_latch)
            seg_out = floor_segments(dest);
    endfunction

    // arrival, then latched floors in ascending order; zero-group trips
    // arrive at once and the scan starts over
    function automatic void finish_trip();
        logic again;
        logic found;
        again = 1'b1;
        while (again) begin
            again          = 1'b0;
            found          = 1'b0;
            car_moving     = 1'b0;
            on_latched_run = 1'b0;
            car_floor      = car_dest;
            seg_out        = floor_segments(car_floor);
            for (int f = 0; f < 3; f++) begin
                if (!found && calls_latched[f[1:0]]) begin
                    calls_latched[f[1:0]] = 1'b0;
                    if (f != car_floor) begin
                        found = 1'b1;
                        begin_trip(f[1:0], 1'b1);
                        if (groups_left == 0) begin
                            again = 1'b1;
                        end else begin
                            car_moving = 1'b1;
                            coil_out   = coil_for_phase();
                        end
                    end
                end
            end
        end
    endfunction

    // advance the model by one word and return the status it produces
    function automatic result_t next_car_status(input logic [3:0] btn, input logic tick);
        int          cf;
        int unsigned limit;
        logic        arrived;
        result_t     r;
        cf      = called_floor(btn);
        arrived = 1'b0;
        if (!car_moving) begin
            // idle: hold as it stood before this word gates the call
            if (!hold_on && cf >= 0 && cf != car_floor) begin
                begin_trip(cf[1:0], 1'b0);
                if (groups_left == 0) begin
                    finish_trip();
                end else begin
                    car_moving = 1'b1;
                    coil_out   = coil_for_phase();
                end
            end
            hold_on = (btn == BTN_HOLD);
        end else begin
            if (!on_latched_run && cf >= 0 && cf != car_dest)
                calls_latched[cf[1:0]] = 1'b1;
            if (tick) begin
                limit    = (cfg_phase_ticks == 0) ? 1 : cfg_phase_ticks;
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= limit) begin
                    tick_cnt   = 16'd0;
                    coil_phase = coil_phase + 2'd1;
                    if (coil_phase == 2'd0) begin
                        if (groups_left != 0)
                            groups_left = groups_left - 13'd1;
                        if (groups_left == 0) begin
                            arrived = 1'b1;
                            finish_trip();
                        end
                    end
                    if (!arrived)
                        coil_out = coil_for_phase();
                end
            end
        end
        r.coils         = coil_out;
        r.segments      = seg_out;
        r.current_floor = car_floor;
        r.moving        = car_moving;
        r.held          = hold_on;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side: random backpressure
    // ------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            if (rx_stalls_on) begin
                m_tready <= 1'b0;
                repeat (pick_gap()) @(posedge aclk);
            end
        end
    end

    task automatic flag_field(input string name, input int unsigned want,
                              input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("word %0d %s: expected 0x%0h, got 0x%0h",
                     words_checked, name, want, got);
    endtask

    // compare each accepted status word with the oldest prediction
    always @(posedge aclk) begin : check_status
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[14:0];
            words_checked++;
            if (car_status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d unexpected: 0x%0h", words_checked, m_tdata);
            end else begin
                want = car_status_q.pop_front();
                if (got.coils !== want.coils)
                    flag_field("coils", want.coils, got.coils);
                if (got.segments !== want.segments)
                    flag_field("segments", want.segments, got.segments);
                if (got.current_floor !== want.current_floor)
                    flag_field("current_floor", want.current_floor, got.current_floor);
                if (got.moving !== want.moving)
                    flag_field("moving", want.moving, got.moving);
                if (got.held !== want.held)
                    flag_field("held", want.held, got.held);
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // one word, predicted when the handshake completes
    task automatic send_word(input logic [3:0] btn, input logic tick);
        int    gap;
        item_t w;
        gap = (tx_gaps_on && $urandom_range(0, 99) >= 40) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        w.buttons = btn;
        w.tick    = tick;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, w};
        do @(posedge aclk); while (!s_tready);
        car_status_q.push_back(next_car_status(btn, tick));
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (car_status_q.size() != 0) @(posedge aclk);
    endtask

    // register write with nothing in flight
    task automatic program_reg(input cfg_index_t idx, input logic [15:0] value);
        wait_drain();
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_PHASE_TICKS: cfg_phase_ticks = value;
            REG_STEP_GROUPS: cfg_step_groups = value[11:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // plain ticks until the car stands with nothing latched
    task automatic run_to_rest();
        while (car_moving) send_word(BTN_NONE, 1'b1);
    endtask

    function automatic logic [3:0] random_buttons();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            case ($urandom_range(0, 2))
                0:       return BTN_FLOOR0;
                1:       return BTN_FLOOR1;
                default: return BTN_FLOOR2;
            endcase
        end
        if (r < 65) return BTN_HOLD;
        if (r < 75) return BTN_NONE;
        return 4'($urandom_range(0, 15));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // idle behavior at reset settings: current floor, hold, odd patterns
    task automatic test_idle_buttons();
        send_word(BTN_NONE, 1'b0);
        send_word(BTN_FLOOR0, 1'b1);
        send_word(BTN_HOLD, 1'b0);
        send_word(BTN_FLOOR2, 1'b0);
        send_word(BTN_HOLD, 1'b1);
        send_word(BTN_ALL, 1'b1);
    endtask

    // trip up two floors, calls latched on the way, served lowest first
    task automatic test_latched_trip();
        program_reg(REG_PHASE_TICKS, 16'd1);
        program_reg(REG_STEP_GROUPS, 16'd1);
        send_word(BTN_FLOOR2, 1'b0);
        send_word(BTN_FLOOR1, 1'b1);
        send_word(BTN_FLOOR0, 1'b1);
        send_word(BTN_FLOOR2, 1'b1);
        send_word(BTN_HOLD, 1'b0);
        run_to_rest();
    endtask

    // zero phase ticks and zero groups, instant arrival chain
    task automatic test_zero_settings();
        program_reg(REG_PHASE_TICKS, 16'd0);
        program_reg(REG_STEP_GROUPS, 16'd0);
        send_word(BTN_FLOOR2, 1'b0);
        send_word(BTN_FLOOR0, 1'b1);
        send_word(BTN_FLOOR1, 1'b0);
        program_reg(REG_STEP_GROUPS, 16'd1);
        send_word(car_floor == 2'd2 ? BTN_FLOOR0 : BTN_FLOOR2, 1'b0);
        send_word(BTN_FLOOR0, 1'b0);
        send_word(BTN_FLOOR1, 1'b0);
        send_word(BTN_FLOOR2, 1'b0);
        // groups go to zero while the car is out: latched trips arrive at once
        program_reg(REG_STEP_GROUPS, 16'd0);
        run_to_rest();
    endtask

    // long move over many groups, largest phase hold for a while
    task automatic test_extremes();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        program_reg(REG_PHASE_TICKS, 16'd1);
        program_reg(REG_STEP_GROUPS, 16'd30);
        send_word(car_floor == 2'd1 ? BTN_FLOOR2 : BTN_FLOOR1, 1'b1);
        run_to_rest();
        program_reg(REG_PHASE_TICKS, 16'd65535);
        program_reg(REG_STEP_GROUPS, 16'd1);
        send_word(car_floor == 2'd0 ? BTN_FLOOR1 : BTN_FLOOR0, 1'b0);
        repeat (40) send_word(random_buttons(), 1'b1);
        program_reg(REG_PHASE_TICKS, 16'd1);
        run_to_rest();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // random traffic under several small settings
    task automatic test_random_traffic();
        logic [15:0] ticks_set [6] = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1, 16'd4};
        logic [15:0] groups_set[6] = '{16'd1, 16'd3, 16'd2, 16'd0, 16'd4, 16'd1};
        for (int i = 0; i < 6; i++) begin
            program_reg(REG_PHASE_TICKS, ticks_set[i]);
            program_reg(REG_STEP_GROUPS, groups_set[i]);
            // one setting runs with no idling on either side
            tx_gaps_on   = (i != 2);
            rx_stalls_on = (i != 2);
            repeat (170)
                send_word(random_buttons(), $urandom_range(0, 99) < 75);
            run_to_rest();
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'd0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = REG_PHASE_TICKS;
        cfg_wr_data  = 16'd0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_buttons();
        test_latched_trip();
        test_zero_settings();
        test_extremes();
        test_random_traffic();

        wait_drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && car_status_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: three_floor_elevator_controller.f
+incdir+hw/rtl
hw/rtl/tfec_pkg.sv
hw/rtl/tfec_in_reg.sv
hw/rtl/tfec_ctrl.sv
hw/rtl/three_floor_elevator_controller.sv
tb/tb_three_floor_elevator_controller.sv
